[design/pfb_pkg.sv]
package pfb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int FMT_W    = 2;
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 13;
    localparam int STRIDE_W = 15;
    localparam int ROW_W    = 12;
    localparam int SUM_W    = 20;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    localparam logic [FMT_W-1:0] FMT_RGB32  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_YUY2   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_STRIDE = 2'd3;

    localparam logic [FMT_W-1:0]    RST_FORMAT = FMT_RGB24;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 13'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 15'd1920;

    // Effective frame geometry handed to the front end
    typedef struct packed {
        logic [FMT_W-1:0]    mode;
        logic [HEIGHT_W-1:0] height;
        logic [STRIDE_W-1:0] used;
        logic [STRIDE_W-1:0] stride;
        logic                restart;
    } t_cfg;

    // One completed group. For YUY2 the bytes are Y0 U Y1 V, else B G R A.
    typedef struct packed {
        logic       yuy2;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        logic       row_last;
        logic       frame_last;
    } t_job;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       row_end;
        logic       frame_end;
        logic       run_last;
    } t_pix;

    // Round by 128, shift by 8, clamp to 0..255
    function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] t;
        t = sum + SUM_W'(128);
        if (t < 0) begin
            return 8'd0;
        end else if (t[SUM_W-1:8] > (SUM_W-8)'(255)) begin
            return 8'd255;
        end else begin
            return t[15:8];
        end
    endfunction

endpackage

[design/pfb_if.sv]
interface pfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface pfb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       row_end;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output blue, output green, output red, output alpha,
                    output row_end, output frame_end, output run_last, input ready);
    modport sink (input valid, input blue, input green, input red, input alpha,
                  input row_end, input frame_end, input run_last, output ready);
endinterface

[design/pfb_cfg_regs.sv]
module pfb_cfg_regs
    import pfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [FMT_W-1:0]    r_format;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [STRIDE_W-1:0] r_stride;
    logic                wr_en;
    logic [1:0]          reg_sel;
    logic [WIDTH_W-1:0]  w_clamp;
    logic [WIDTH_W-1:0]  w_eff;
    logic [STRIDE_W-1:0] used;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= RST_FORMAT;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_stride <= RST_STRIDE;
        end else if (wr_en) begin
            case (reg_sel)
                REG_FORMAT: r_format <= pwdata[FMT_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                REG_STRIDE: r_stride <= pwdata[STRIDE_W-1:0];
                default:    r_format <= r_format;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FORMAT: prdata = 32'(r_format);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_STRIDE: prdata = 32'(r_stride);
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            w_clamp = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_clamp = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_clamp = r_width;
        end

        w_eff = w_clamp;
        if (r_format == FMT_YUY2) begin
            w_eff = {w_clamp[WIDTH_W-1:1], 1'b0};
            if (w_eff == '0) begin
                w_eff = WIDTH_W'(2);
            end
        end

        case (r_format)
            FMT_RGB32: used = {w_eff, 2'b00};
            FMT_YUY2:  used = {1'b0, w_eff, 1'b0};
            FMT_RGB24: used = {1'b0, w_eff, 1'b0} + STRIDE_W'(w_eff);
            default:   used = '0;
        endcase

        o_cfg.mode    = r_format;
        o_cfg.used    = used;
        o_cfg.stride  = (r_stride < used) ? used : r_stride;
        o_cfg.restart = wr_en;
        if (r_height == '0) begin
            o_cfg.height = HEIGHT_W'(1);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            o_cfg.height = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end
    end

endmodule

[design/pfb_front.sv]
module pfb_front
    import pfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    pfb_byte_if.sink i_byte,
    input  logic   i_job_full,
    output logic   o_job_push,
    output t_job   o_job
);

    logic [STRIDE_W-1:0] r_pos;
    logic [ROW_W-1:0]    r_row;
    logic [1:0]          r_phase;
    logic [7:0]          r_held [3];

    logic                take;
    logic                in_used;
    logic                group_done;
    logic [1:0]          last_phase;
    logic [STRIDE_W:0]   pos_inc;
    logic [ROW_W:0]      row_inc;
    logic                row_last;

    assign i_byte.ready = !i_job_full;
    assign take         = i_byte.valid && i_byte.ready && (i_cfg.mode != FMT_UNUSED);

    assign last_phase = (i_cfg.mode == FMT_RGB24) ? 2'd2 : 2'd3;
    assign in_used    = r_pos < i_cfg.used;
    assign group_done = in_used && (r_phase == last_phase);
    assign pos_inc    = {1'b0, r_pos} + 1'b1;
    assign row_inc    = {1'b0, r_row} + 1'b1;
    assign row_last   = pos_inc == {1'b0, i_cfg.used};

    assign o_job_push = take && group_done;

    always_comb begin
        o_job.yuy2       = i_cfg.mode == FMT_YUY2;
        o_job.p0         = r_held[0];
        o_job.p1         = r_held[1];
        o_job.row_last   = row_last;
        o_job.frame_last = row_last && (row_inc >= i_cfg.height);
        if (i_cfg.mode == FMT_RGB24) begin
            o_job.p2 = i_byte.byte_in;
            o_job.p3 = 8'd255;
        end else begin
            o_job.p2 = r_held[2];
            o_job.p3 = i_byte.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_pos   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (take) begin
            if (in_used) begin
                r_phase <= group_done ? 2'd0 : r_phase + 2'd1;
            end
            if (pos_inc >= {1'b0, i_cfg.stride}) begin
                // wrap to the next row, and to the next frame after the last row
                r_pos   <= '0;
                r_phase <= '0;
                r_row   <= (row_inc >= i_cfg.height) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_pos <= pos_inc[STRIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_held[2] <= '0;
        end else if (take && in_used && !group_done) begin
            r_held[r_phase] <= i_byte.byte_in;
        end
    end

endmodule

[design/pfb_job_fifo.sv]
module pfb_job_fifo
    import pfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wptr;
    logic [JOB_PTR_W-1:0] r_rptr;
    logic [JOB_PTR_W:0]   r_count;

    assign o_full  = r_count == (JOB_PTR_W+1)'(JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[design/pfb_back.sv]
module pfb_back
    import pfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_empty,
    input  t_job i_job,
    output logic o_job_pop,
    pfb_pix_if.source o_pix
);

    logic r_half;
    logic r_valid;
    t_pix r_pix;
    t_pix n_pix;
    logic load;

    logic signed [8:0]       c;
    logic signed [8:0]       d;
    logic signed [8:0]       e;
    logic signed [SUM_W-1:0] yc;
    logic signed [SUM_W-1:0] ub;
    logic signed [SUM_W-1:0] ug;
    logic signed [SUM_W-1:0] vg;
    logic signed [SUM_W-1:0] vr;

    assign load      = !i_job_empty && (!r_valid || o_pix.ready);
    assign o_job_pop = load && (!i_job.yuy2 || r_half);

    always_comb begin
        c  = $signed({1'b0, (r_half ? i_job.p2 : i_job.p0)}) - 9'sd16;
        d  = $signed({1'b0, i_job.p1}) - 9'sd128;
        e  = $signed({1'b0, i_job.p3}) - 9'sd128;
        yc = SUM_W'(c) * SUM_W'(298);
        ub = SUM_W'(d) * SUM_W'(516);
        ug = SUM_W'(d) * SUM_W'(100);
        vg = SUM_W'(e) * SUM_W'(208);
        vr = SUM_W'(e) * SUM_W'(409);

        if (i_job.yuy2) begin
            n_pix.blue  = clamp_shift(yc + ub);
            n_pix.green = clamp_shift(yc - ug - vg);
            n_pix.red   = clamp_shift(yc + vr);
            n_pix.alpha = 8'd255;
        end else begin
            n_pix.blue  = i_job.p0;
            n_pix.green = i_job.p1;
            n_pix.red   = i_job.p2;
            n_pix.alpha = i_job.p3;
        end
        // the first YUY2 pixel never closes a row or the group's run
        n_pix.run_last  = !i_job.yuy2 || r_half;
        n_pix.row_end   = n_pix.run_last && i_job.row_last;
        n_pix.frame_end = n_pix.run_last && i_job.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= i_job.yuy2 && !r_half;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix.valid     = r_valid;
    assign o_pix.blue      = r_pix.blue;
    assign o_pix.green     = r_pix.green;
    assign o_pix.red       = r_pix.red;
    assign o_pix.alpha     = r_pix.alpha;
    assign o_pix.row_end   = r_pix.row_end;
    assign o_pix.frame_end = r_pix.frame_end;
    assign o_pix.run_last  = r_pix.run_last;

endmodule

[design/pixel_format_to_bgra32.sv]
// Throughput: one byte per cycle while the group queue is not full; pixels leave
//   at up to one per cycle. The byte that completes a group enters the queue, and
//   its pixel is then registered. A YUY2 group heads the queue for both pixels.
// A four-entry group queue separates the byte counters from the pixel datapath.
// Reset is synchronous, active low: counters and queue clear, registers reload
//   their defaults. Any register write restarts the frame.
module pixel_format_to_bgra32
    import pfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfb_byte_if.sink    i_byte,
    pfb_pix_if.source   o_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_job push_job;
    t_job head_job;
    logic job_push;
    logic job_pop;
    logic job_full;
    logic job_empty;

    pfb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_byte     (i_byte),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    pfb_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_head  (head_job)
    );

    pfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .o_pix       (o_pix)
    );

endmodule
